[hdl/rpf_pkg.sv]
`default_nettype none
package rpf_pkg;

   localparam int HEADER_BYTES  = 8;
   localparam int TRAILER_BYTES = 2;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [1:0] CSR_SYNC_FIRST   = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND  = 2'd1;
   localparam logic [1:0] CSR_MESSAGE_TYPE = 2'd2;

   localparam logic [7:0] SYNC_FIRST_RESET   = 8'h48;
   localparam logic [7:0] SYNC_SECOND_RESET  = 8'h65;
   localparam logic [7:0] MESSAGE_TYPE_RESET = 8'h10;

   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      CMD_ERROR,
      CMD_HEADER,
      CMD_DATA,
      CMD_LAST
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                  kind;
      logic                          empty_frame;
      logic [HEADER_BYTES-1:0][7:0]  bytes;
   } cmd_type;

endpackage
`default_nettype wire

[hdl/rpf_req_if.sv]
`default_nettype none
interface rpf_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  command;
   logic [7:0]  data_count;
   logic [15:0] ack_value;
   logic [7:0]  data_byte;

   modport source (output valid, func, command, data_count, ack_value, data_byte,
                   input ready);
   modport sink   (input valid, func, command, data_count, ack_value, data_byte,
                   output ready);
endinterface
`default_nettype wire

[hdl/rpf_rsp_if.sv]
`default_nettype none
interface rpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic       error;

   modport source (output valid, out_byte, frame_end, error, input ready);
   modport sink   (input valid, out_byte, frame_end, error, output ready);
endinterface
`default_nettype wire

[hdl/rpf_front.sv]
`default_nettype none
module rpf_front #(
   parameter int MAX_FRAME = 265
) (
   input  wire logic      clock,
   input  wire logic      reset,
   rpf_req_if.sink        req_chan,
   input  wire logic      csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   output logic           push,
   output rpf_pkg::cmd_type push_cmd,
   input  wire logic      push_ready
);

   logic [7:0] sync_first_ff,  sync_first_in;
   logic [7:0] sync_second_ff, sync_second_in;
   logic [7:0] msg_type_ff,    msg_type_in;
   logic [7:0] sum_low_ff,     sum_low_in;
   logic [7:0] sum_high_ff,    sum_high_in;
   logic [7:0] bytes_left_ff,  bytes_left_in;
   logic       frame_open_ff,  frame_open_in;

   logic        accept;
   logic [15:0] len_field;
   logic [7:0]  hdr [rpf_pkg::HEADER_BYTES];
   logic [7:0]  hs_low, hs_high;
   logic [7:0]  cs_low1, cs_high1, cs_low2, cs_high2;
   logic [7:0]  ps_low, ps_high;
   logic [16:0] frame_total;
   logic        oversize;
   logic        plen_zero;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign push           = accept;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      msg_type_in    = msg_type_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rpf_pkg::CSR_SYNC_FIRST:   sync_first_in  = csr_wdata;
            rpf_pkg::CSR_SYNC_SECOND:  sync_second_in = csr_wdata;
            rpf_pkg::CSR_MESSAGE_TYPE: msg_type_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      plen_zero   = (req_chan.data_count == 8'd0);
      len_field   = plen_zero ? req_chan.ack_value : {8'd0, req_chan.data_count};
      frame_total = 17'(req_chan.data_count)
                  + 17'(rpf_pkg::HEADER_BYTES + rpf_pkg::TRAILER_BYTES);
      oversize    = !plen_zero && (frame_total > 17'(MAX_FRAME));

      hdr[0] = sync_first_ff;
      hdr[1] = sync_second_ff;
      hdr[2] = msg_type_ff;
      hdr[3] = req_chan.command;
      hdr[4] = len_field[15:8];
      hdr[5] = len_field[7:0];
      hs_low  = 8'd0;
      hs_high = 8'd0;
      for (int k = 2; k < 6; k++) begin
         hs_low  = hs_low + hdr[k];
         hs_high = hs_high + hs_low;
      end
      hdr[6] = hs_low;
      hdr[7] = hs_high;

      // running sums continue over the two header sum bytes
      cs_low1  = hs_low + hs_low;
      cs_high1 = hs_high + cs_low1;
      cs_low2  = cs_low1 + hs_high;
      cs_high2 = cs_high1 + cs_low2;

      ps_low  = sum_low_ff + req_chan.data_byte;
      ps_high = sum_high_ff + ps_low;
   end

   always_comb begin
      sum_low_in    = sum_low_ff;
      sum_high_in   = sum_high_ff;
      bytes_left_in = bytes_left_ff;
      frame_open_in = frame_open_ff;
      push_cmd.kind        = rpf_pkg::CMD_ERROR;
      push_cmd.empty_frame = 1'b0;
      push_cmd.bytes       = '0;
      if (req_chan.func == rpf_pkg::FUNC_START) begin
         sum_low_in    = 8'd0;
         sum_high_in   = 8'd0;
         bytes_left_in = 8'd0;
         frame_open_in = 1'b0;
         if (!oversize) begin
            push_cmd.kind        = rpf_pkg::CMD_HEADER;
            push_cmd.empty_frame = plen_zero;
            for (int k = 0; k < rpf_pkg::HEADER_BYTES; k++) begin
               push_cmd.bytes[k] = hdr[k];
            end
            if (!plen_zero) begin
               sum_low_in    = cs_low2;
               sum_high_in   = cs_high2;
               bytes_left_in = req_chan.data_count;
               frame_open_in = 1'b1;
            end
         end
      end else if (frame_open_ff && (bytes_left_ff != 8'd0)) begin
         push_cmd.bytes[0] = req_chan.data_byte;
         if (bytes_left_ff == 8'd1) begin
            push_cmd.kind     = rpf_pkg::CMD_LAST;
            push_cmd.bytes[1] = ps_low;
            push_cmd.bytes[2] = ps_high;
            sum_low_in        = 8'd0;
            sum_high_in       = 8'd0;
            bytes_left_in     = 8'd0;
            frame_open_in     = 1'b0;
         end else begin
            push_cmd.kind = rpf_pkg::CMD_DATA;
            sum_low_in    = ps_low;
            sum_high_in   = ps_high;
            bytes_left_in = bytes_left_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= rpf_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= rpf_pkg::SYNC_SECOND_RESET;
         msg_type_ff    <= rpf_pkg::MESSAGE_TYPE_RESET;
         sum_low_ff     <= 8'd0;
         sum_high_ff    <= 8'd0;
         bytes_left_ff  <= 8'd0;
         frame_open_ff  <= 1'b0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         msg_type_ff    <= msg_type_in;
         if (accept) begin
            sum_low_ff    <= sum_low_in;
            sum_high_ff   <= sum_high_in;
            bytes_left_ff <= bytes_left_in;
            frame_open_ff <= frame_open_in;
         end
      end
   end

endmodule
`default_nettype wire

[hdl/rpf_queue.sv]
`default_nettype none
module rpf_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rpf_pkg::cmd_type push_cmd,
   output logic                  push_ready,
   output logic                  pop_valid,
   output rpf_pkg::cmd_type      pop_cmd,
   input  wire logic             pop
);

   localparam int PtrW = (rpf_pkg::QUEUE_DEPTH > 1) ? $clog2(rpf_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(rpf_pkg::QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(rpf_pkg::QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(rpf_pkg::QUEUE_DEPTH);

   rpf_pkg::cmd_type mem_ff [rpf_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff,  count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

[hdl/rpf_back.sv]
`default_nettype none
module rpf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             pop_valid,
   input  wire rpf_pkg::cmd_type pop_cmd,
   output logic                  pop,
   rpf_rsp_if.source             rsp_chan
);

   localparam int IdxW = $clog2(rpf_pkg::HEADER_BYTES);
   localparam logic [IdxW-1:0] HdrLast = IdxW'(rpf_pkg::HEADER_BYTES - 1);
   localparam logic [IdxW-1:0] TrlLast = IdxW'(rpf_pkg::TRAILER_BYTES);

   logic [IdxW-1:0] idx_ff, idx_in;
   logic            valid_ff, valid_in;
   logic [7:0]      byte_ff, byte_in;
   logic            end_ff, end_in;
   logic            err_ff, err_in;
   logic            load;
   logic [IdxW-1:0] last_idx;

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.out_byte  = byte_ff;
   assign rsp_chan.frame_end = end_ff;
   assign rsp_chan.error     = err_ff;

   assign load = !valid_ff || rsp_chan.ready;

   always_comb begin
      case (pop_cmd.kind)
         rpf_pkg::CMD_HEADER: last_idx = HdrLast;
         rpf_pkg::CMD_LAST:   last_idx = TrlLast;
         default:             last_idx = '0;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      err_in   = err_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = pop_valid;
         if (pop_valid) begin
            byte_in = pop_cmd.bytes[idx_ff];
            err_in  = (pop_cmd.kind == rpf_pkg::CMD_ERROR);
            end_in  = ((pop_cmd.kind == rpf_pkg::CMD_LAST) && (idx_ff == TrlLast))
                   || ((pop_cmd.kind == rpf_pkg::CMD_HEADER) && pop_cmd.empty_frame
                       && (idx_ff == HdrLast));
            if (err_in) begin
               byte_in = 8'd0;
            end
            if (idx_ff == last_idx) begin
               pop    = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
      err_ff  <= err_in;
   end

endmodule
`default_nettype wire

[hdl/radio_packet_framer.sv]
// Radio packet framer: turns start and payload requests into a framed byte
// stream with 8-bit Fletcher header and payload checksums.
// req_chan: valid/ready request channel. func 0 starts a frame (command,
//   data_count, ack_value); func 1 carries one payload byte.
// rsp_chan: valid/ready byte stream (out_byte, frame_end, error).
// csr_*: write-only registers 0 sync_first, 1 sync_second, 2 message_type;
//   write only while no request is in flight.
// A request's first byte is registered in the queue and then in the output register.
// Throughput: one response byte per cycle while rsp_chan.ready holds; a start
//   emits 8 bytes (one error byte if oversize), the last payload byte 3, any
//   other request 1. The output register stepping through one queued request at a time sets this.
// A 2-entry queue sits between the request classifier and the byte
//   sequencer, so requests are taken while response bytes are pending.
// Reset clears the frame state, the queue and the output valid flag, and
//   restores the register defaults 0x48, 0x65, 0x10.
// When rsp_chan stalls the output holds, the queue fills and req_chan.ready
//   drops until space frees up.
`default_nettype none
module radio_packet_framer #(
   parameter int MAX_FRAME = 265
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rpf_req_if.sink         req_chan,
   rpf_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   logic             push, push_ready;
   rpf_pkg::cmd_type push_cmd;
   logic             pop, pop_valid;
   rpf_pkg::cmd_type pop_cmd;

   rpf_front #(.MAX_FRAME(MAX_FRAME)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   rpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   rpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

[tb/sv/radio_packet_framer_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module radio_packet_framer_test;

   localparam int FRAME_LIMIT  = 265;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int QUIET_LIMIT  = 2000;

   typedef struct {
      logic [7:0] value;
      logic       frame_end;
      logic       error;
   } stream_byte_type;

   class framer_scoreboard_type;
      logic [7:0]      sync_first;
      logic [7:0]      sync_second;
      logic [7:0]      message_type;
      logic [7:0]      fletcher_low;
      logic [7:0]      fletcher_high;
      logic [15:0]     bytes_left;
      bit              frame_open;
      int              max_frame;
      int              errors;
      stream_byte_type expected_stream[$];

      function new(int frame_limit);
         max_frame     = frame_limit;
         sync_first    = rpf_pkg::SYNC_FIRST_RESET;
         sync_second   = rpf_pkg::SYNC_SECOND_RESET;
         message_type  = rpf_pkg::MESSAGE_TYPE_RESET;
         fletcher_low  = 8'h00;
         fletcher_high = 8'h00;
         bytes_left    = 16'h0000;
         frame_open    = 1'b0;
         errors        = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [7:0] value);
         case (index)
            rpf_pkg::CSR_SYNC_FIRST:   sync_first   = value;
            rpf_pkg::CSR_SYNC_SECOND:  sync_second  = value;
            rpf_pkg::CSR_MESSAGE_TYPE: message_type = value;
            default: ;
         endcase
      endfunction

      function void fold(logic [7:0] b);
         fletcher_low  = fletcher_low + b;
         fletcher_high = fletcher_high + fletcher_low;
      endfunction

      function void push_byte(logic [7:0] value, logic frame_end, logic error);
         stream_byte_type sb;
         sb.value     = value;
         sb.frame_end = frame_end;
         sb.error     = error;
         expected_stream.push_back(sb);
      endfunction

      function void note_request(logic func, logic [7:0] command, logic [7:0] plen,
                                 logic [15:0] ack, logic [7:0] data);
         logic [7:0]  hdr [rpf_pkg::HEADER_BYTES];
         logic [15:0] len_field;
         int          total;
         if (func == rpf_pkg::FUNC_START) begin
            frame_open    = 1'b0;
            bytes_left    = 16'h0000;
            fletcher_low  = 8'h00;
            fletcher_high = 8'h00;
            total = rpf_pkg::HEADER_BYTES + int'(plen) + rpf_pkg::TRAILER_BYTES;
            if (plen != 8'h00 && total > max_frame) begin
               push_byte(8'h00, 1'b0, 1'b1);
               return;
            end
            len_field = (plen != 8'h00) ? {8'h00, plen} : ack;
            hdr[0] = sync_first;
            hdr[1] = sync_second;
            hdr[2] = message_type;
            hdr[3] = command;
            hdr[4] = len_field[15:8];
            hdr[5] = len_field[7:0];
            for (int k = 2; k < 6; k++) fold(hdr[k]);
            hdr[6] = fletcher_low;
            hdr[7] = fletcher_high;
            if (plen != 8'h00) begin
               fold(hdr[6]);
               fold(hdr[7]);
               bytes_left = {8'h00, plen};
               frame_open = 1'b1;
            end else begin
               fletcher_low  = 8'h00;
               fletcher_high = 8'h00;
            end
            for (int k = 0; k < rpf_pkg::HEADER_BYTES; k++)
               push_byte(hdr[k], (plen == 8'h00) && (k == rpf_pkg::HEADER_BYTES - 1),
                         1'b0);
         end else if (!frame_open || bytes_left == 16'h0000) begin
            push_byte(8'h00, 1'b0, 1'b1);
         end else begin
            fold(data);
            push_byte(data, 1'b0, 1'b0);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'h0000) begin
               push_byte(fletcher_low, 1'b0, 1'b0);
               push_byte(fletcher_high, 1'b1, 1'b0);
               fletcher_low  = 8'h00;
               fletcher_high = 8'h00;
               frame_open    = 1'b0;
            end
         end
      endfunction

      function void check_byte(logic [7:0] out_byte, logic frame_end, logic error);
         stream_byte_type want;
         if (expected_stream.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: byte %02h end %0b error %0b",
                     $time, out_byte, frame_end, error);
            return;
         end
         want = expected_stream.pop_front();
         if (want.value !== out_byte || want.frame_end !== frame_end ||
             want.error !== error) begin
            errors++;
            $display("%0t: mismatch: expected byte %02h end %0b error %0b,",
                     $time, want.value, want.frame_end, want.error,
                     " got byte %02h end %0b error %0b",
                     out_byte, frame_end, error);
         end
      endfunction

      function int pending();
         return expected_stream.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   rpf_req_if req_bus ();
   rpf_rsp_if rsp_bus ();

   framer_scoreboard_type frame_check = new(FRAME_LIMIT);

   int items_sent = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   bit hold_off_request = 1'b0;

   radio_packet_framer #(.MAX_FRAME(FRAME_LIMIT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         frame_check.note_request(req_bus.func, req_bus.command, req_bus.data_count,
                                  req_bus.ack_value, req_bus.data_byte);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         frame_check.check_byte(rsp_bus.out_byte, rsp_bus.frame_end, rsp_bus.error);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response stall pattern: rotates through free, random, sparse and mostly-ready
   initial begin : response_sink
      int rx_cycle;
      int mode;
      rx_cycle = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (hold_off_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            mode = (rx_cycle / 101) % 4;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (rx_cycle % 5) == 0;
               default: rsp_bus.ready <= $urandom_range(0, 3) != 0;
            endcase
         end
      end
   end

   task automatic send_request(input logic func, input logic [7:0] command,
                               input logic [7:0] plen, input logic [15:0] ack,
                               input logic [7:0] data);
      if (burst_left == 0) begin
         if (gaps_on) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.func       <= func;
      req_bus.command    <= command;
      req_bus.data_count <= plen;
      req_bus.ack_value  <= ack;
      req_bus.data_byte  <= data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      items_sent++;
   endtask

   task automatic send_frame(input int plen, input int payload_count);
      send_request(rpf_pkg::FUNC_START, 8'($urandom), 8'(plen), 16'($urandom),
                   8'($urandom));
      repeat (payload_count)
         send_request(rpf_pkg::FUNC_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                      8'($urandom));
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (frame_check.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_registers(input logic [7:0] first, input logic [7:0] second,
                                 input logic [7:0] mtype);
      csr_wr_en <= 1'b1;
      csr_index <= rpf_pkg::CSR_SYNC_FIRST;
      csr_wdata <= first;
      @(posedge clock);
      frame_check.set_register(rpf_pkg::CSR_SYNC_FIRST, first);
      csr_index <= rpf_pkg::CSR_SYNC_SECOND;
      csr_wdata <= second;
      @(posedge clock);
      frame_check.set_register(rpf_pkg::CSR_SYNC_SECOND, second);
      csr_index <= rpf_pkg::CSR_MESSAGE_TYPE;
      csr_wdata <= mtype;
      @(posedge clock);
      frame_check.set_register(rpf_pkg::CSR_MESSAGE_TYPE, mtype);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_traffic(input int quota);
      int first_item;
      int kind;
      int plen;
      first_item = items_sent;
      while (items_sent - first_item < quota) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_frame(plen, plen);
         end else if (kind < 85) begin
            // abandoned frame: sent with fewer payload bytes than its length
            plen = $urandom_range(2, 12);
            send_frame(plen, $urandom_range(0, plen - 1));
         end else if (kind < 93) begin
            send_frame(0, 0);
         end else begin
            send_request(rpf_pkg::FUNC_PAYLOAD, 8'($urandom), 8'($urandom),
                         16'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= rpf_pkg::CSR_SYNC_FIRST;
      csr_wdata          <= 8'h00;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= rpf_pkg::FUNC_START;
      req_bus.command    <= 8'h00;
      req_bus.data_count <= 8'h00;
      req_bus.ack_value  <= 16'h0000;
      req_bus.data_byte  <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values; empty frames carry the ack value
      send_request(rpf_pkg::FUNC_START, 8'h00, 8'd0, 16'h0000, 8'($urandom));
      send_request(rpf_pkg::FUNC_START, 8'hFF, 8'd0, 16'hFFFF, 8'($urandom));
      // payload with no frame open
      send_request(rpf_pkg::FUNC_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                   8'hAA);
      send_request(rpf_pkg::FUNC_START, 8'h5A, 8'd1, 16'($urandom), 8'($urandom));
      send_request(rpf_pkg::FUNC_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                   8'hFF);
      send_request(rpf_pkg::FUNC_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                   8'h00);
      // longest frame, abandoned by a new start
      send_request(rpf_pkg::FUNC_START, 8'h81, 8'd255, 16'($urandom), 8'($urandom));
      send_request(rpf_pkg::FUNC_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                   8'h00);
      send_request(rpf_pkg::FUNC_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                   8'hFF);
      send_request(rpf_pkg::FUNC_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                   8'h55);
      send_frame(2, 2);
      drain_responses();

      load_registers(8'h00, 8'h00, 8'h00);
      send_request(rpf_pkg::FUNC_START, 8'h00, 8'd0, 16'h0000, 8'($urandom));
      send_frame(3, 3);
      drain_responses();

      load_registers(8'hFF, 8'hFF, 8'hFF);
      send_request(rpf_pkg::FUNC_START, 8'hFF, 8'd0, 16'hFFFF, 8'($urandom));
      send_request(rpf_pkg::FUNC_START, 8'hFF, 8'd1, 16'hFFFF, 8'($urandom));
      send_request(rpf_pkg::FUNC_PAYLOAD, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);

      for (int phase = 0; phase < 5; phase++) begin
         drain_responses();
         load_registers(8'($urandom), 8'($urandom), 8'($urandom));
         gaps_on = (phase != 1);
         if (phase == 2) hold_off_request = 1'b1;
         if (phase == 3) send_frame(60, 60);
         random_traffic(30);
      end
      drain_responses();

      if (frame_check.errors == 0 && frame_check.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

[radio_packet_framer.f]
hdl/rpf_pkg.sv
hdl/rpf_req_if.sv
hdl/rpf_rsp_if.sv
hdl/rpf_front.sv
hdl/rpf_queue.sv
hdl/rpf_back.sv
hdl/radio_packet_framer.sv
tb/sv/radio_packet_framer_test.sv
